### hdl/fwhc_pkg.sv
// Package for the firmware image header check: magic words, signatures,
// verdict codes and the reflected CRC-32 byte step. No dependencies.
package fwhc_pkg;

  localparam int unsigned SEARCH_SPAN_DEFAULT = 512;

  localparam logic [31:0] MAGIC_TRX      = 32'h3052_4448;
  localparam logic [31:0] MAGIC_CHK      = 32'h5E24_232A;
  localparam logic [31:0] SIG_U2ND       = 32'h5532_4E44;
  localparam logic [31:0] SIG_HDR0       = 32'h4844_5230;
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_LEN_RESET  = 32'h0400_0000;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0] HEADER_BYTES   = 32'd12;
  localparam logic [31:0] MIN_IMAGE_LAST = 32'd31;

  localparam logic [1:0] STATUS_VALID    = 2'd0;
  localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd3;

  localparam logic [1:0] KIND_TRX        = 2'd0;
  localparam logic [1:0] KIND_CHK        = 2'd1;
  localparam logic [1:0] KIND_GENERIC    = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN    = 2'd3;

  localparam logic       REG_MAX_LEN     = 1'b0;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = {24'd0, c[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CRC_POLY ^ {1'b0, r[31:1]}) : {1'b0, r[31:1]};
    end
    return r ^ {8'd0, c[31:8]};
  endfunction

endpackage

### hdl/fwhc_if.sv
// Valid/ready channel interfaces for image bytes and verdict words.
// Depends on nothing.
interface fwhc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface fwhc_verdict_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  image_kind;
  logic [31:0] computed_crc;
  modport source (output valid, output status, output image_kind, output computed_crc,
                  input ready);
  modport sink (input valid, input status, input image_kind, input computed_crc,
                output ready);
endinterface

### hdl/firmware_image_header_check.sv
// Firmware image header check: one byte word per cycle, one verdict word per image.
// Depends on fwhc_pkg and the channel interfaces in fwhc_if.sv.
// The verdict is registered and shown in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; bytes keep flowing while a verdict waits, and
// only the last byte of the next image is held until that verdict is taken.
// Reset (rst, synchronous, active high) clears stream state and the verdict
// valid flag, and sets max_image_len to 0x4000000.
module firmware_image_header_check #(
  parameter int unsigned SEARCH_SPAN = fwhc_pkg::SEARCH_SPAN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  fwhc_byte_if.sink             image,
  fwhc_verdict_if.source        verdict
);

  localparam int unsigned MW = (SEARCH_SPAN > 1) ? $clog2(SEARCH_SPAN) : 1;

  logic [31:0]   max_image_len;
  logic [31:0]   byte_count;
  logic [31:0]   magic_word;
  logic [31:0]   declared_len;
  logic [31:0]   expected_crc;
  logic [31:0]   crc_reg;
  logic [23:0]   recent_bytes;
  logic [MW-1:0] earliest_match;
  logic          match_seen;

  logic [31:0]   magic_next, len_next, exp_next, crc_next, win, idx_m3, shifted;
  logic [MW-1:0] match_pos_next;
  logic          match_next, accept, hit;
  logic [1:0]    status_next, kind_next;
  logic [31:0]   crc_out_next;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fwhc_pkg::REG_MAX_LEN) ? max_image_len : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_image_len <= fwhc_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == fwhc_pkg::REG_MAX_LEN) begin
      max_image_len <= pwdata;
    end
  end

  assign image.ready = !verdict.valid || verdict.ready || !image.last;
  assign accept      = image.valid && image.ready;
  assign win         = {recent_bytes, image.data_byte};
  assign idx_m3      = byte_count - 32'd3;
  assign shifted     = {24'd0, image.data_byte} << {byte_count[1:0], 3'b000};

  always_comb begin
    magic_next = magic_word;
    len_next   = declared_len;
    exp_next   = expected_crc;
    crc_next   = crc_reg;
    priority if (byte_count < 32'd4) begin
      magic_next = magic_word | shifted;
    end else if (byte_count < 32'd8) begin
      len_next = declared_len | shifted;
    end else if (byte_count < fwhc_pkg::HEADER_BYTES) begin
      exp_next = expected_crc | shifted;
    end else if (byte_count < declared_len) begin
      crc_next = fwhc_pkg::crc_byte(crc_reg, image.data_byte);
    end else begin
      crc_next = crc_reg;
    end

    hit = (byte_count >= 32'd3) && !match_seen && idx_m3 < 32'(SEARCH_SPAN)
          && (win == fwhc_pkg::SIG_U2ND || win == fwhc_pkg::SIG_HDR0);
    match_next     = match_seen || hit;
    match_pos_next = hit ? idx_m3[MW-1:0] : earliest_match;

    crc_out_next = 32'd0;
    priority if (byte_count < fwhc_pkg::MIN_IMAGE_LAST) begin
      status_next = fwhc_pkg::STATUS_BAD_LEN;
      kind_next   = fwhc_pkg::KIND_UNKNOWN;
    end else if (magic_next == fwhc_pkg::MAGIC_TRX) begin
      kind_next = fwhc_pkg::KIND_TRX;
      if (len_next < fwhc_pkg::HEADER_BYTES
          || {1'b0, len_next} > ({1'b0, byte_count} + 33'd1)
          || len_next > max_image_len) begin
        status_next = fwhc_pkg::STATUS_BAD_LEN;
      end else begin
        crc_out_next = crc_next;
        status_next  = (crc_next == exp_next) ? fwhc_pkg::STATUS_VALID
                                              : fwhc_pkg::STATUS_CRC_BAD;
      end
    end else if (magic_next == fwhc_pkg::MAGIC_CHK) begin
      status_next = fwhc_pkg::STATUS_VALID;
      kind_next   = fwhc_pkg::KIND_CHK;
    end else if (match_next && 32'(match_pos_next) < (byte_count - fwhc_pkg::MIN_IMAGE_LAST)) begin
      status_next = fwhc_pkg::STATUS_VALID;
      kind_next   = fwhc_pkg::KIND_GENERIC;
    end else begin
      status_next = fwhc_pkg::STATUS_UNKNOWN;
      kind_next   = fwhc_pkg::KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && image.last)) begin
      byte_count     <= 32'd0;
      magic_word     <= 32'd0;
      declared_len   <= 32'd0;
      expected_crc   <= 32'd0;
      crc_reg        <= fwhc_pkg::CRC_INIT;
      recent_bytes   <= 24'd0;
      earliest_match <= '0;
      match_seen     <= 1'b0;
    end else if (accept) begin
      if (byte_count != fwhc_pkg::COUNT_MAX) begin
        byte_count <= byte_count + 32'd1;
      end
      magic_word     <= magic_next;
      declared_len   <= len_next;
      expected_crc   <= exp_next;
      crc_reg        <= crc_next;
      recent_bytes   <= win[23:0];
      earliest_match <= match_pos_next;
      match_seen     <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (accept && image.last) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && image.last) begin
      verdict.status       <= status_next;
      verdict.image_kind   <= kind_next;
      verdict.computed_crc <= crc_out_next;
    end
  end

endmodule

### test/fwhc_check_pkg.sv
`timescale 1ns / 100ps
// Verdict predictor and scoreboard for the firmware image header check bench.
// Depends on fwhc_pkg for magic words, signatures, verdict codes and reset values.
package fwhc_check_pkg;
  import fwhc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [31:0] crc;
  } verdict_t;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  class verdict_scoreboard;
    logic [31:0] max_len;
    logic [31:0] pos;
    logic [31:0] magic;
    logic [31:0] decl_len;
    logic [31:0] stored_crc;
    logic [31:0] crc_acc;
    logic [23:0] tail;
    logic [31:0] sig_at;
    bit          sig_found;
    verdict_t    verdicts_due[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned bytes_seen;
    int unsigned by_status[4];

    function new();
      max_len = MAX_LEN_RESET;
      errors = 0;
      checked = 0;
      bytes_seen = 0;
      for (int i = 0; i < 4; i++) by_status[i] = 0;
      restart();
    endfunction

    function void restart();
      pos = '0;
      magic = '0;
      decl_len = '0;
      stored_crc = '0;
      crc_acc = CRC_INIT;
      tail = '0;
      sig_at = '0;
      sig_found = 0;
    endfunction

    function void set_max_len(input logic [31:0] v);
      max_len = v;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void note_byte(input logic [7:0] b, input logic is_last);
      logic [31:0] idx;
      logic [31:0] word;
      logic [63:0] size;
      verdict_t    v;
      int          sh;
      idx = pos;
      word = {tail, b};
      sh = int'(idx[1:0]) * 8;
      bytes_seen++;
      if (idx < 4) begin
        magic |= {24'd0, b} << sh;
      end else if (idx < 8) begin
        decl_len |= {24'd0, b} << sh;
      end else if (idx < HEADER_BYTES) begin
        stored_crc |= {24'd0, b} << sh;
      end else if (idx < decl_len) begin
        crc_acc = crc32_step(crc_acc, b);
      end
      if (idx >= 3 && !sig_found && (word == SIG_U2ND || word == SIG_HDR0)
          && (idx - 32'd3) < SEARCH_SPAN_DEFAULT) begin
        sig_found = 1;
        sig_at = idx - 32'd3;
      end
      tail = word[23:0];
      if (pos != COUNT_MAX) pos++;
      if (!is_last) return;

      size = {32'd0, idx} + 64'd1;
      v.crc = '0;
      if (size < 64'd32) begin
        v.status = STATUS_BAD_LEN;
        v.kind = KIND_UNKNOWN;
      end else if (magic == MAGIC_TRX) begin
        v.kind = KIND_TRX;
        if (decl_len < HEADER_BYTES || {32'd0, decl_len} > size || decl_len > max_len) begin
          v.status = STATUS_BAD_LEN;
        end else begin
          v.crc = crc_acc;
          v.status = (crc_acc == stored_crc) ? STATUS_VALID : STATUS_CRC_BAD;
        end
      end else if (magic == MAGIC_CHK) begin
        v.status = STATUS_VALID;
        v.kind = KIND_CHK;
      end else if (sig_found && {32'd0, sig_at} < size - 64'd32) begin
        v.status = STATUS_VALID;
        v.kind = KIND_GENERIC;
      end else begin
        v.status = STATUS_UNKNOWN;
        v.kind = KIND_UNKNOWN;
      end
      verdicts_due.push_back(v);
      restart();
    endfunction

    function void check_verdict(input logic [1:0] status, input logic [1:0] kind,
                                input logic [31:0] crc);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict status %0d kind %0d crc 0x%h", $time,
                 status, kind, crc);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      checked++;
      by_status[want.status]++;
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        errors++;
      end
      if (kind !== want.kind) begin
        $display("%0t: image_kind expected %0d, got %0d", $time, want.kind, kind);
        errors++;
      end
      if (crc !== want.crc) begin
        $display("%0t: computed_crc expected 0x%h, got 0x%h", $time, want.crc, crc);
        errors++;
      end
    endfunction
  endclass

endpackage

### test/firmware_image_header_check_test.sv
`timescale 1ns / 100ps
// Top-level bench for firmware_image_header_check: streams TRX, CHK, generic and
// malformed images under several length limits. Depends on fwhc_pkg, fwhc_if.sv, fwhc_check_pkg.
module firmware_image_header_check_test;
  import fwhc_pkg::*;
  import fwhc_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_BYTES = 80;
  localparam logic [2:0]  MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fwhc_byte_if    image ();
  fwhc_verdict_if verdict ();

  firmware_image_header_check #(
    .SEARCH_SPAN(SEARCH_SPAN_DEFAULT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .image(image),
    .verdict(verdict)
  );

  verdict_scoreboard sb;
  logic [7:0]  img[$];
  bit          calm;
  int unsigned hold_start;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned cycles;
  int unsigned limits_used;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // verdict receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      verdict.ready <= 1'b0;
    end else if (hold_seen != hold_start) begin
      hold_seen = hold_start;
      hold_left = HOLD_CYCLES;
      verdict.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      verdict.ready <= 1'b0;
    end else begin
      verdict.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (!rst && verdict.valid && verdict.ready)
      sb.check_verdict(verdict.status, verdict.image_kind, verdict.computed_crc);
  end

  task automatic write_max_len(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_LEN_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_max_len(v);
    limits_used++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== v) begin
      $display("%0t: max_image_len read back 0x%h, wrote 0x%h", $time, prdata, v);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_image();
    for (int i = 0; i < img.size(); i++) begin
      while (!calm && $urandom_range(99) < 16) begin
        image.valid <= 1'b0;
        @(posedge clk);
      end
      image.valid <= 1'b1;
      image.data_byte <= img[i];
      image.last <= (i == img.size() - 1);
      do @(posedge clk); while (!image.ready);
      sb.note_byte(img[i], i == img.size() - 1);
    end
  endtask

  task automatic fill_image(input int unsigned size, input bit rnd, input logic [7:0] value);
    img.delete();
    for (int unsigned i = 0; i < size; i++) img.push_back(rnd ? 8'($urandom()) : value);
  endtask

  task automatic put_word_le(input int unsigned at, input logic [31:0] w);
    for (int k = 0; k < 4; k++) img[at + k] = w[8*k +: 8];
  endtask

  task automatic make_trx(input int unsigned size, input logic [31:0] dlen, input bit corrupt);
    logic [31:0] c;
    fill_image(size, 1, 8'h00);
    put_word_le(0, MAGIC_TRX);
    put_word_le(4, dlen);
    if (dlen >= HEADER_BYTES && dlen <= size) begin
      c = CRC_INIT;
      for (int unsigned i = HEADER_BYTES; i < dlen; i++) c = crc32_step(c, img[i]);
    end else begin
      c = $urandom();
    end
    if (corrupt) c ^= 32'd1 << $urandom_range(31);
    put_word_le(8, c);
  endtask

  task automatic make_generic(input int unsigned size, input logic [31:0] sig,
                              input int unsigned off);
    fill_image(size, 1, 8'h00);
    if (off + 4 <= size) begin
      for (int k = 0; k < 4; k++) img[off + k] = sig[31 - 8*k -: 8];
    end
  endtask

  task automatic make_chk(input int unsigned size);
    fill_image(size, 1, 8'h00);
    put_word_le(0, MAGIC_CHK);
  endtask

  task automatic make_random_image();
    int unsigned size;
    int unsigned pick;
    logic [31:0] dlen;
    pick = $urandom_range(99);
    size = ($urandom_range(24) == 0) ? $urandom_range(33, 600) : $urandom_range(32, 72);
    if (pick < 30) begin
      make_trx(size, $urandom_range(12, size), 0);
    end else if (pick < 40) begin
      make_trx(size, $urandom_range(12, size), 1);
    end else if (pick < 50) begin
      case ($urandom_range(2))
        0: dlen = $urandom_range(0, 11);
        1: dlen = size + $urandom_range(1, 1000);
        default: dlen = $urandom() | 32'h8000_0000;
      endcase
      make_trx(size, dlen, 0);
    end else if (pick < 60) begin
      make_chk(size);
    end else if (pick < 80) begin
      make_generic(size, $urandom_range(1) ? SIG_HDR0 : SIG_U2ND,
                   (size == 32 || $urandom_range(3) == 0) ? $urandom_range(size - 32, size - 4)
                                                          : $urandom_range(0, size - 33));
    end else if (pick < 90) begin
      make_trx(32, 32, 0);
      size = $urandom_range(1, 31);
      while (img.size() > size) img.pop_back();
    end else begin
      fill_image(size, 1, 8'h00);
    end
  endtask

  task automatic run_random(input int unsigned budget, input int hold_at, input int pause_at);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_start <= hold_start + 1;
        hold_at = -1;
      end
      if (pause_at >= 0 && sent >= pause_at) begin
        image.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        pause_at = -1;
      end
      make_random_image();
      send_image();
      sent += img.size();
    end
    image.valid <= 1'b0;
  endtask

  task automatic run_directed();
    fill_image(1, 1, 8'h00);
    send_image();
    make_trx(32, 32, 0);
    void'(img.pop_back());
    send_image();
    fill_image(32, 0, 8'h00);
    send_image();
    fill_image(40, 0, 8'hFF);
    send_image();
    make_trx(32, 32, 0);
    send_image();
    make_trx(40, 12, 0);
    send_image();
    make_trx(48, 30, 1);
    send_image();
    make_trx(40, 11, 0);
    send_image();
    make_trx(40, 0, 0);
    send_image();
    make_trx(40, 41, 0);
    send_image();
    make_trx(40, 32'hFFFF_FFFF, 0);
    send_image();
    make_chk(32);
    send_image();
    make_generic(33, SIG_U2ND, 0);
    send_image();
    make_generic(33, SIG_HDR0, 1);
    send_image();
    make_generic(64, SIG_U2ND, 31);
    send_image();
    make_generic(64, SIG_HDR0, 32);
    send_image();
    make_generic(548, SIG_HDR0, SEARCH_SPAN_DEFAULT - 1);
    send_image();
    make_generic(548, SIG_U2ND, SEARCH_SPAN_DEFAULT);
    send_image();
    image.valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    image.valid = 1'b0;
    image.data_byte = '0;
    image.last = 1'b0;
    calm = 0;
    hold_start = 0;
    hold_seen = 0;
    hold_left = 0;
    cycles = 0;
    limits_used = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_max_len(MAX_LEN_RESET);
    run_directed();
    drain();

    write_max_len(32'hFFFF_FFFF);
    run_random(PHASE_BYTES, 0, -1);
    drain();

    write_max_len(32'd0);
    run_random(PHASE_BYTES, -1, 40);
    drain();

    write_max_len(32'd48);
    calm <= 1;
    run_random(PHASE_BYTES, -1, -1);
    drain();
    calm <= 0;

    write_max_len($urandom_range(32, 80));
    run_random(PHASE_BYTES, -1, -1);
    drain();

    repeat (8) @(posedge clk);
    $display("Checked %0d verdicts over %0d image bytes under %0d length limits.",
             sb.checked, sb.bytes_seen, limits_used);
    $display("Verdicts: %0d valid, %0d crc mismatch, %0d bad length, %0d unrecognised.",
             sb.by_status[STATUS_VALID], sb.by_status[STATUS_CRC_BAD],
             sb.by_status[STATUS_BAD_LEN], sb.by_status[STATUS_UNKNOWN]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/fwhc_pkg.sv
hdl/fwhc_if.sv
hdl/firmware_image_header_check.sv
test/fwhc_check_pkg.sv
test/firmware_image_header_check_test.sv
